// ----- sv/sha_mh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and round functions of the SHA-256 message hasher.
// Used by the front, the request queue and the compression core.
package sha_mh_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned CountW     = 3;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned RoundW     = 6;
  localparam int unsigned LenW       = 64;

  localparam logic [CountW-1:0] FullBytes   = 3'd4;
  localparam logic [CountW-1:0] LastIndex   = 3'd7;
  localparam logic [RoundW-1:0] LastRound   = 6'd63;
  localparam logic [3:0]        FillLenHi   = 4'd14;
  localparam logic [3:0]        FillLast    = 4'd15;
  localparam logic [WordW-1:0]  MarkerWord  = 32'h8000_0000;

  localparam logic [WordW-1:0] InitValue [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One queued request: the word as it enters the block buffer.
  typedef struct packed {
    logic [WordW-1:0]  word;    // already masked and marked when partial
    logic [CountW-1:0] bytes;   // 0..4 message bytes carried
    logic              last;    // ends the message
    logic              marker;  // full last word: marker word still to follow
  } sha_mh_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sha_mh_state_e;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

// ----- sv/sha_mh_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Front of the SHA-256 hasher: classifies incoming words and forms queue entries.
// Depends on sha_mh_pkg.
module sha_mh_front
  import sha_mh_pkg::*;
(
  input  wire logic [WordW-1:0]  data_word_i,
  input  wire logic [CountW-1:0] byte_count_i,
  input  wire logic              eom_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              q_ready_i,
  output logic                   push_o,
  output sha_mh_entry_t          entry_o
);

  logic [CountW-1:0] bytes;
  logic              drop;
  logic              last;

  always_comb begin
    bytes = (byte_count_i > FullBytes) ? FullBytes : byte_count_i;
    // a zero count that does not end the message carries nothing
    drop  = (bytes == '0) && !eom_i;
    last  = eom_i || (bytes != FullBytes);

    entry_o.bytes  = bytes;
    entry_o.last   = last;
    entry_o.marker = last && (bytes == FullBytes);
    // keep the valid leading bytes and place the 0x80 marker right after them
    unique case (bytes)
      3'd0:    entry_o.word = MarkerWord;
      3'd1:    entry_o.word = {data_word_i[31:24], 24'h80_0000};
      3'd2:    entry_o.word = {data_word_i[31:16], 16'h8000};
      3'd3:    entry_o.word = {data_word_i[31:8], 8'h80};
      default: entry_o.word = data_word_i;
    endcase
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i && !drop;

endmodule
`default_nettype wire

// ----- sv/sha_mh_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Short request queue between the front and the compression core.
// Depends on sha_mh_pkg.
module sha_mh_fifo
  import sha_mh_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sha_mh_entry_t entry_i,
  output logic               ready_o,
  output logic               valid_o,
  output sha_mh_entry_t      entry_o,
  input  wire logic          pop_i
);

  sha_mh_entry_t       mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoPtrW:0]   count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign ready_o = (count_q != FifoPtrW'(0) + (FifoPtrW+1)'(FifoDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    do_push  = push_i && ready_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (FifoPtrW+1)'(do_push) - (FifoPtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sha_mh_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Back end of the SHA-256 hasher: block buffer, padding, 64-round compression
// and digest output. Depends on sha_mh_pkg.
module sha_mh_core
  import sha_mh_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire sha_mh_entry_t     q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [WordW-1:0]       digest_o,
  output logic [CountW-1:0]      index_o,
  output logic                   last_o
);

  sha_mh_state_e     state_q, state_d;
  logic [WordW-1:0]  chain_q [8];
  logic [WordW-1:0]  chain_d [8];
  logic [WordW-1:0]  vars_q [8];
  logic [WordW-1:0]  vars_d [8];
  logic [WordW-1:0]  sched_q [16];
  logic [WordW-1:0]  sched_d [16];
  logic [3:0]        fill_q, fill_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [RoundW-1:0] round_q, round_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic              pad_q, pad_d;
  logic              marker_q, marker_d;
  logic              hi_done_q, hi_done_d;
  logic              done_q, done_d;

  logic              push;
  logic [WordW-1:0]  push_word;
  logic              shift;
  logic [WordW-1:0]  shift_word;
  logic [WordW-1:0]  t1;
  logic [WordW-1:0]  t2;
  logic [WordW-1:0]  new_w;

  assign digest_o    = chain_q[idx_q];
  assign index_o     = idx_q;
  assign last_o      = (idx_q == LastIndex);
  assign out_valid_o = (state_q == ST_OUT);

  // round datapath
  always_comb begin
    t1 = vars_q[7] + big_sigma1(vars_q[4])
       + (vars_q[6] ^ (vars_q[4] & (vars_q[5] ^ vars_q[6])))
       + RoundK[round_q] + sched_q[0];
    t2 = big_sigma0(vars_q[0])
       + ((vars_q[0] & vars_q[1]) | (vars_q[2] & (vars_q[0] | vars_q[1])));
    new_w = small_sigma1(sched_q[14]) + sched_q[9] + small_sigma0(sched_q[1]) + sched_q[0];
  end

  always_comb begin
    state_d   = state_q;
    chain_d   = chain_q;
    vars_d    = vars_q;
    fill_d    = fill_q;
    len_d     = len_q;
    round_d   = round_q;
    idx_d     = idx_q;
    pad_d     = pad_q;
    marker_d  = marker_q;
    hi_done_d = hi_done_q;
    done_d    = done_q;
    q_pop_o   = 1'b0;
    push      = 1'b0;
    push_word = '0;
    shift     = 1'b0;
    shift_word = new_w;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          push      = 1'b1;
          push_word = q_entry_i.word;
          len_d     = len_q + LenW'({q_entry_i.bytes, 3'b000});
          if (q_entry_i.last) begin
            pad_d    = 1'b1;
            marker_d = q_entry_i.marker;
            state_d  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push = 1'b1;
        priority if (marker_q) begin
          push_word = MarkerWord;
          marker_d  = 1'b0;
        end else if (hi_done_q) begin
          push_word = len_q[WordW-1:0];
          done_d    = 1'b1;
        end else if (fill_q == FillLenHi) begin
          push_word = len_q[LenW-1:WordW];
          hi_done_d = 1'b1;
        end else begin
          push_word = '0;
        end
      end
      ST_ROUND: begin
        // consume W[r] from the head, shift in W[r+16]
        shift     = 1'b1;
        vars_d[0] = t1 + t2;
        vars_d[1] = vars_q[0];
        vars_d[2] = vars_q[1];
        vars_d[3] = vars_q[2];
        vars_d[4] = vars_q[3] + t1;
        vars_d[5] = vars_q[4];
        vars_d[6] = vars_q[5];
        vars_d[7] = vars_q[6];
        round_d   = round_q + 1'b1;
        if (round_q == LastRound) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + vars_q[i];
        end
        priority if (done_q) begin
          state_d = ST_OUT;
          idx_d   = '0;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == LastIndex) begin
            chain_d   = InitValue;
            len_d     = '0;
            fill_d    = '0;
            pad_d     = 1'b0;
            marker_d  = 1'b0;
            hi_done_d = 1'b0;
            done_d    = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // block buffer write: a full buffer starts a compression
    if (push) begin
      shift      = 1'b1;
      shift_word = push_word;
      fill_d     = fill_q + 1'b1;
      if (fill_q == FillLast) begin
        state_d = ST_ROUND;
        round_d = '0;
        vars_d  = chain_q;
      end
    end

    for (int i = 0; i < 15; i++) begin
      sched_d[i] = shift ? sched_q[i+1] : sched_q[i];
    end
    sched_d[15] = shift ? shift_word : sched_q[15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chain_q   <= InitValue;
      fill_q    <= '0;
      len_q     <= '0;
      round_q   <= '0;
      idx_q     <= '0;
      pad_q     <= 1'b0;
      marker_q  <= 1'b0;
      hi_done_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      chain_q   <= chain_d;
      fill_q    <= fill_d;
      len_q     <= len_d;
      round_q   <= round_d;
      idx_q     <= idx_d;
      pad_q     <= pad_d;
      marker_q  <= marker_d;
      hi_done_q <= hi_done_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q  <= vars_d;
    sched_q <= sched_d;
  end

endmodule
`default_nettype wire

// ----- sv/sha256_message_hasher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the SHA-256 message hasher: front, request queue and core.
// Depends on sha_mh_pkg, sha_mh_front, sha_mh_fifo and sha_mh_core.
//
// SHA-256 over a stream of big-endian 32-bit words (first message byte in
// bits 31:24). Each input request carries 0 to 4 valid leading bytes in
// s_axis_tuser; tlast or a count below four ends the message, and a count of
// zero with tlast hashes what came before (an empty message if nothing did).
// A zero count without tlast is dropped. On end of message the block appends
// the 0x80 marker, zero padding and the 64-bit bit length, then sends eight
// digest requests, most significant word first, with the word position on
// m_axis_tuser and tlast on the eighth, and rearms for a new message.
// Rate: the core takes one queued word per cycle while it is idle and runs
// one round per cycle; the shared round unit limits throughput, since no
// word is taken while the core pads, compresses or drains the digest. The
// last block adds the padding words, possibly a second block, and the eight
// digest requests. A four-entry queue lets the front keep accepting while
// the core compresses or the digest waits.
module sha256_message_hasher
  import sha_mh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] data_word
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] byte_count
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_index
  output logic             m_axis_tlast    // last
);

  logic          push;
  logic          q_ready;
  logic          q_valid;
  logic          q_pop;
  sha_mh_entry_t push_entry;
  sha_mh_entry_t pop_entry;

  // classify the request and form the buffer word
  sha_mh_front u_front (
    .data_word_i  (s_axis_tdata),
    .byte_count_i (s_axis_tuser),
    .eom_i        (s_axis_tlast),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .q_ready_i    (q_ready),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // hold classified words while the core compresses
  sha_mh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .entry_o (pop_entry),
    .pop_i   (q_pop)
  );

  // fill, pad, compress and drain the digest
  sha_mh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .digest_o    (m_axis_tdata),
    .index_o     (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ----- sv/sha_mh_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the SHA-256 message hasher, bound to its top level.
// Depends on sha256_message_hasher.
module sha_mh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // tlast marks exactly the eighth digest word
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
    else $error("tlast does not match word index");

  // digest words leave in order without gaps
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("digest word index did not advance");

  // a new digest needs a whole compression first
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("digest output did not drop after last word");

  // a stalled digest request holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled digest request changed");

endmodule

bind sha256_message_hasher sha_mh_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ----- sim/sha256_message_hasher_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of sha256_message_hasher: messages of random length
// stream in, a SHA-256 predictor computes the digests, and a scoreboard checks them.
// Depends on the sha256_message_hasher RTL and its package only.
module sha256_message_hasher_test;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] MARKER = 32'h8000_0000;
  localparam int unsigned ITEM_TARGET = 270;
  localparam int unsigned MAX_PRINTS = 100;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  // Hashes the accepted requests and holds the digest words still to come.
  class digest_scoreboard;
    logic [31:0]  chain [8];
    logic [31:0]  msg_block [16];
    logic [3:0]   fill;
    logic [63:0]  bit_len;
    digest_beat_t digests_due [$];
    int unsigned  errors;

    function new();
      chain   = SHA_IV;
      fill    = '0;
      bit_len = '0;
      errors  = 0;
      foreach (msg_block[i]) msg_block[i] = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wr, s0, s1, ch, mj, t1, t2, w15, w2;
      w = msg_block;
      v = chain;
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          wr = w[r];
        end else begin
          // extend the schedule in place, sixteen words deep
          w15 = w[(r - 15) % 16];
          w2  = w[(r - 2) % 16];
          s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
          s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
          wr  = w[r % 16] + s0 + w[(r - 7) % 16] + s1;
          w[r % 16] = wr;
        end
        s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
        ch = v[6] ^ (v[4] & (v[5] ^ v[6]));
        t1 = v[7] + s1 + ch + SHA_K[r] + wr;
        s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
        mj = (v[0] & v[1]) | (v[2] & (v[0] | v[1]));
        t2 = s0 + mj;
        for (int i = 7; i > 0; i--) v[i] = v[i - 1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    function void push_word(logic [31:0] w);
      msg_block[fill] = w;
      fill = fill + 4'd1;
      if (fill == 4'd0) compress();
    endfunction

    // Apply one accepted request; queue the digest when it ends the message.
    function void note_request(logic [31:0] data, logic [2:0] count, logic eom);
      int unsigned n, shift;
      logic [31:0] kept;
      n = (count > 3'd4) ? 4 : count;
      if (n == 0 && !eom) return;
      // a partial word closes the message even without tlast
      if (n < 4) eom = 1'b1;
      bit_len = bit_len + 64'(n * 8);
      if (!eom) begin
        push_word(data);
        return;
      end
      if (n == 4) begin
        push_word(data);
        push_word(MARKER);
      end else begin
        shift = 8 * (4 - n);
        kept  = (n == 0) ? 32'h0 : (data & (32'hFFFF_FFFF << shift));
        push_word(kept | (32'h80 << (shift - 8)));
      end
      while (fill != 4'd14) push_word(32'h0);
      push_word(bit_len[63:32]);
      push_word(bit_len[31:0]);
      for (int i = 0; i < 8; i++) begin
        digests_due.push_back('{word: chain[i], index: 3'(i), last: (i == 7)});
      end
      chain   = SHA_IV;
      bit_len = '0;
      fill    = '0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task check_digest(digest_beat_t got);
      digest_beat_t want;
      if (digests_due.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h index %0d last %b",
                                  got.word, got.index, got.last));
        return;
      end
      want = digests_due.pop_front();
      if (got.word !== want.word || got.index !== want.index || got.last !== want.last) begin
        report_mismatch($sformatf("digest got %h/%0d/%b want %h/%0d/%b",
                                  got.word, got.index, got.last,
                                  want.word, want.index, want.last));
      end
    endtask

    function int unsigned pending();
      return digests_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  wire logic   m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire logic [31:0] m_axis_tdata;
  wire logic [2:0]  m_axis_tuser;
  wire logic        m_axis_tlast;

  digest_scoreboard sb;
  int unsigned req_gap_pct = 0;
  int unsigned dig_stall_pct = 0;
  int unsigned dig_hold_cycles = 0;
  int unsigned items_sent = 0;

  sha256_message_hasher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [31:0] data_word
    .s_axis_tuser  (s_axis_tuser),    // [2:0] byte_count
    .s_axis_tlast  (s_axis_tlast),    // end_of_message
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [31:0] digest_word
    .m_axis_tuser  (m_axis_tuser),    // [2:0] word_index
    .m_axis_tlast  (m_axis_tlast)     // last
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Digest side: a long hold-off first when asked, else random stalls.
  initial begin
    forever begin
      @(negedge clk_i);
      if (dig_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        dig_hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= dig_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_digest('{word: m_axis_tdata, index: m_axis_tuser, last: m_axis_tlast});
    end
  end

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(input logic [31:0] data, input logic [2:0] count,
                              input logic eom);
    @(negedge clk_i);
    while ($urandom_range(99) < req_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= count;
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(data, count, eom);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One message of random length; mostly well formed, with some noise.
  task automatic send_random_message();
    int unsigned nwords, tail;
    logic [2:0] cnt;
    nwords = ($urandom_range(99) < 5) ? $urandom_range(30, 40) : $urandom_range(0, 17);
    for (int i = 0; i < nwords; i++) begin
      // drop in a zero-count request now and then; the block must ignore it
      if ($urandom_range(99) < 8) send_request(pick_word(), 3'd0, 1'b0);
      cnt = ($urandom_range(99) < 10) ? 3'($urandom_range(5, 7)) : 3'd4;
      send_request(pick_word(), cnt, 1'b0);
    end
    tail = $urandom_range(99);
    if (tail < 35)      send_request(pick_word(), 3'd4, 1'b1);
    else if (tail < 42) send_request(pick_word(), 3'($urandom_range(5, 7)), 1'b1);
    else if (tail < 75) send_request(pick_word(), 3'($urandom_range(1, 3)), 1'b1);
    else if (tail < 88) send_request(pick_word(), 3'($urandom_range(1, 3)), 1'b0);
    else                send_request(pick_word(), 3'd0, 1'b1);
  endtask

  initial begin
    int unsigned gap_tab [4];
    int unsigned stall_tab [4];
    gap_tab   = '{0, 69, 0, 19};
    stall_tab = '{0, 0, 69, 19};
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Stall the digest side for a long stretch so results back up into the input.
    dig_hold_cycles = 700;

    send_request(32'h0000_0000, 3'd0, 1'b1);   // empty message
    send_request(32'hFFFF_FFFF, 3'd1, 1'b1);   // single byte
    send_request(32'h0000_0000, 3'd4, 1'b1);   // full word that ends the message
    send_request(32'hABCD_EF01, 3'd0, 1'b0);   // zero count, not last: ignored
    send_request(32'hFFFF_FFFF, 3'd2, 1'b0);   // partial word closes without tlast
    send_request(32'h1234_5678, 3'd7, 1'b0);   // counts above four act as four
    send_request(32'h9ABC_DEF0, 3'd5, 1'b1);
    send_request(32'hDEAD_BEEF, 3'd6, 1'b0);
    send_request(32'hCAFE_F00D, 3'd3, 1'b1);
    // 56 bytes: the length no longer fits, so padding spills into a second block
    for (int i = 0; i < 14; i++) send_request(32'h6162_6364 + 32'(i), 3'd4, 1'b0);
    send_request(32'h0000_0000, 3'd0, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      req_gap_pct   = gap_tab[ph];
      dig_stall_pct = stall_tab[ph];
      while (items_sent < (ph + 1) * ITEM_TARGET / 4) send_random_message();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // Drain the digests, then give the block time to show any stray output.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("digest words never arrived");
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
